>>> rtl/isotp_segment_reassemble_engine_unit_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ISOTP_SEGMENT_REASSEMBLE_ENGINE_UNIT_MACROS_SVH
`define ISOTP_SEGMENT_REASSEMBLE_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, held off during reset.
`define ISOTP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isotp: same-cycle check failed");
// Next-cycle implication, sampled on clk, held off during reset.
`define ISOTP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isotp: next-cycle check failed");
`else
`define ISOTP_ASSERT_IMP(label, ante, cons)
`define ISOTP_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> rtl/isotp_pkg.sv
package isotp_pkg;

	localparam int unsigned MAX_MSG_BYTES_DEF = 4096;
	localparam int unsigned LEN_W = 12;
	localparam int unsigned GAP_W = 17;

	localparam logic [GAP_W-1:0] GAP_MAX       = 17'h1FFFF;
	localparam logic [GAP_W-1:0] MIN_GAP_RESET = 17'd5000;
	localparam logic [GAP_W-1:0] US_PER_MS     = 17'd1000;
	localparam logic [GAP_W-1:0] US_STEP       = 17'd100;
	localparam logic [GAP_W-1:0] FALLBACK_GAP  = 17'd127000;
	localparam logic [7:0]       SEP_MS_MAX    = 8'd127;
	localparam logic [7:0]       SEP_US_LO     = 8'hF1;
	localparam logic [7:0]       SEP_US_HI     = 8'hF9;

	// item modes
	localparam logic [1:0] MODE_FRAME = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;

	// protocol control nibbles
	localparam logic [3:0] FT_SINGLE = 4'h0;
	localparam logic [3:0] FT_FIRST  = 4'h1;
	localparam logic [3:0] FT_CONSEC = 4'h2;
	localparam logic [3:0] FT_FLOW   = 4'h3;
	localparam logic [7:0] FLOW_CTS  = 8'h30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_WRITE,
		ACT_READ,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		logic take;
		logic dispatch;
		logic write_step;
		logic read_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic cnt_last;
		logic has_result;
		logic out_free;
	} status_t;

endpackage

>>> rtl/isotp_if.sv
interface isotp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [28:0] can_id;
	logic [3:0]  frame_size;
	logic [63:0] frame_bytes;
	logic [7:0]  req_byte;
	logic        req_last;

	modport source (output valid, mode, can_id, frame_size, frame_bytes, req_byte, req_last,
		input ready);
	modport sink (input valid, mode, can_id, frame_size, frame_bytes, req_byte, req_last,
		output ready);
endinterface

interface isotp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [28:0] out_id;
	logic [63:0] out_frame;
	logic [11:0] msg_length;
	logic [7:0]  data_byte;
	logic        last_byte;

	modport source (output valid, kind, out_id, out_frame, msg_length, data_byte, last_byte,
		input ready);
	modport sink (input valid, kind, out_id, out_frame, msg_length, data_byte, last_byte,
		output ready);
endinterface

>>> rtl/isotp_ram.sv
module isotp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/isotp_ctrl.sv
module isotp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  isotp_pkg::status_t  status,
	output isotp_pkg::cmd_t     cmd
);
	import isotp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (status.act)
					ACT_WRITE: state_d = ST_WRITE;
					ACT_READ:  state_d = ST_READ;
					ACT_EMIT:  state_d = ST_FINISH;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_WRITE: begin
				if (status.cnt_last) state_d = status.has_result ? ST_FINISH : ST_IDLE;
			end
			ST_READ: begin
				if (status.cnt_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd.take       = (state_q == ST_IDLE) && in_valid;
		cmd.dispatch   = (state_q == ST_DISPATCH);
		cmd.write_step = (state_q == ST_WRITE);
		cmd.read_step  = (state_q == ST_READ);
		cmd.emit       = (state_q == ST_FINISH) && status.out_free;
	end
endmodule

>>> rtl/isotp_dp.sv
module isotp_dp #(
	parameter int unsigned MAX_MSG_BYTES = isotp_pkg::MAX_MSG_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	isotp_in_if.sink                        item_in,
	isotp_out_if.source                     result_out,
	input  logic                            cfg_we,
	input  logic [isotp_pkg::GAP_W-1:0]     cfg_wdata,
	input  isotp_pkg::cmd_t                 cmd,
	output isotp_pkg::status_t              status
);
	import isotp_pkg::*;

	localparam int unsigned AW = $clog2(MAX_MSG_BYTES);
	localparam int unsigned TX_LIMIT = (MAX_MSG_BYTES < 4095) ? MAX_MSG_BYTES : 4095;
	localparam logic [LEN_W:0] TX_LIMIT_C = (LEN_W+1)'(TX_LIMIT);
	localparam logic [LEN_W:0] MAX_C = (LEN_W+1)'(MAX_MSG_BYTES);

	// latched item
	logic [1:0]  mode_q;
	logic [28:0] id_q;
	logic [3:0]  size_q;
	logic [7:0]  fb_q [8];
	logic [7:0]  req_byte_q;
	logic        req_last_q;

	// protocol state
	logic [GAP_W-1:0] min_gap_q;
	logic [LEN_W-1:0] rx_length_q, rx_count_q, rp_q, tx_sent_q;
	logic [3:0]       rx_exp_q, tx_seq_q;
	logic [28:0]      rx_msg_id_q, tx_dest_q;
	logic             rx_inprog_q, flow_q;
	logic [LEN_W:0]   tx_length_q;
	logic [7:0]       block_q;
	logic [GAP_W-1:0] gap_q, elapsed_q;

	logic [LEN_W-1:0] d_rx_length, d_rx_count, d_rp, d_tx_sent;
	logic [3:0]       d_rx_exp, d_tx_seq;
	logic [28:0]      d_rx_msg_id, d_tx_dest;
	logic             d_rx_inprog, d_flow;
	logic [LEN_W:0]   d_tx_length;
	logic [7:0]       d_block;
	logic [GAP_W-1:0] d_gap, d_elapsed;

	// loop, result and output registers
	logic [LEN_W-1:0] lp_addr_q, d_lp_addr;
	logic [2:0]       lp_idx_q, d_lp_idx, lp_cnt_q, d_lp_cnt;
	logic [63:0]      frame_q, d_frame;
	logic [1:0]       res_kind_q, d_res_kind;
	logic [28:0]      res_id_q, d_res_id;
	logic [LEN_W-1:0] res_len_q, d_res_len;
	logic             res_last_q, d_res_last, res_pend_q, has_res;
	logic             rd_v_s1;
	logic [2:0]       rd_dst_s1;
	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [28:0]      out_id_q;
	logic [63:0]      out_frame_q;
	logic [LEN_W-1:0] out_len_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	act_t             act;
	logic             abort_c, ld_multi, tx_we;
	logic [3:0]       ftype, nib, size_m1, sz_in;
	logic [LEN_W-1:0] ff_len, rx_rem;
	logic [2:0]       cf_n, tn;
	logic [LEN_W:0]   tl_eff, new_tl, tx_rem, sent_new;
	logic [GAP_W-1:0] el_new, g_raw;
	logic [AW-1:0]    tx_waddr;
	logic [7:0]       rx_rdata, tx_rdata, rd_data;

	assign ftype   = fb_q[0][7:4];
	assign nib     = fb_q[0][3:0];
	assign size_m1 = size_q - 4'd1;
	assign ff_len  = {nib, fb_q[1]};
	assign rx_rem  = rx_length_q - rx_count_q;
	assign cf_n    = ({8'd0, size_m1} <= rx_rem) ? size_m1[2:0] : rx_rem[2:0];
	assign tx_rem  = tx_length_q - {1'b0, tx_sent_q};
	assign tn      = (tx_rem < (LEN_W+1)'(7)) ? tx_rem[2:0] : 3'd7;
	assign sent_new = {1'b0, tx_sent_q} + (LEN_W+1)'(tn);
	assign tl_eff  = (tx_sent_q != '0) ? '0 : tx_length_q;
	assign new_tl  = (tl_eff < TX_LIMIT_C) ? tl_eff + (LEN_W+1)'(1) : TX_LIMIT_C + (LEN_W+1)'(1);
	assign tx_we   = (mode_q == MODE_LOAD) && (tl_eff < TX_LIMIT_C);
	assign tx_waddr = tl_eff[AW-1:0];
	assign el_new  = (elapsed_q < GAP_MAX) ? elapsed_q + GAP_W'(1) : elapsed_q;
	assign sz_in   = (item_in.frame_size > 4'd8) ? 4'd8 : item_in.frame_size;

	// separation time to microseconds
	always_comb begin
		if (fb_q[2] <= SEP_MS_MAX) begin
			g_raw = GAP_W'(fb_q[2]) * US_PER_MS;
		end else if (fb_q[2] inside {[SEP_US_LO:SEP_US_HI]}) begin
			g_raw = GAP_W'(fb_q[2][3:0]) * US_STEP;
		end else begin
			g_raw = FALLBACK_GAP;
		end
	end

	// decide the item
	always_comb begin
		d_rx_length = rx_length_q;
		d_rx_count  = rx_count_q;
		d_rp        = rp_q;
		d_tx_sent   = tx_sent_q;
		d_rx_exp    = rx_exp_q;
		d_tx_seq    = tx_seq_q;
		d_rx_msg_id = rx_msg_id_q;
		d_tx_dest   = tx_dest_q;
		d_rx_inprog = rx_inprog_q;
		d_flow      = flow_q;
		d_tx_length = tx_length_q;
		d_block     = block_q;
		d_gap       = gap_q;
		d_elapsed   = elapsed_q;
		d_lp_addr   = '0;
		d_lp_idx    = '0;
		d_lp_cnt    = '0;
		d_frame     = '0;
		d_res_kind  = KIND_FRAME;
		d_res_id    = '0;
		d_res_len   = '0;
		d_res_last  = 1'b0;
		act         = ACT_DONE;
		abort_c     = 1'b0;
		ld_multi    = 1'b0;
		has_res     = 1'b0;
		case (mode_q)
			MODE_FRAME: begin
				if (size_q == 4'd0) begin
					abort_c = 1'b1;
				end else begin
					case (ftype)
						FT_SINGLE: begin
							if (nib == 4'd0 || nib > size_m1) begin
								abort_c = 1'b1;
							end else begin
								d_rx_msg_id = id_q;
								d_rx_length = LEN_W'(nib);
								d_rx_count  = LEN_W'(nib);
								d_rx_exp    = 4'd1;
								d_rx_inprog = 1'b0;
								d_rp        = '0;
								d_lp_idx    = 3'd1;
								d_lp_cnt    = nib[2:0];
								act         = ACT_WRITE;
								has_res     = 1'b1;
								d_res_kind  = KIND_DONE;
								d_res_id    = id_q;
								d_res_len   = LEN_W'(nib);
							end
						end
						FT_FIRST: begin
							if (ff_len < LEN_W'(8) || {1'b0, ff_len} > MAX_C) begin
								abort_c = 1'b1;
							end else begin
								d_rx_msg_id = id_q;
								d_rx_length = ff_len;
								d_rx_count  = LEN_W'(6);
								d_rx_exp    = 4'd1;
								d_rx_inprog = 1'b1;
								d_rp        = '0;
								d_lp_idx    = 3'd2;
								d_lp_cnt    = 3'd6;
								act         = ACT_WRITE;
								has_res     = 1'b1;
								d_res_id    = tx_dest_q;
								d_frame     = {56'd0, FLOW_CTS};
							end
						end
						FT_CONSEC: begin
							if (!rx_inprog_q || nib != rx_exp_q) begin
								abort_c = 1'b1;
							end else begin
								d_rx_count = rx_count_q + LEN_W'(cf_n);
								d_rx_exp   = rx_exp_q + 4'd1;
								if (rx_count_q + LEN_W'(cf_n) == rx_length_q) begin
									d_rx_inprog = 1'b0;
									d_rp        = '0;
									has_res     = 1'b1;
									d_res_kind  = KIND_DONE;
									d_res_id    = rx_msg_id_q;
									d_res_len   = rx_length_q;
								end
								d_lp_addr = rx_count_q;
								d_lp_idx  = 3'd1;
								d_lp_cnt  = cf_n;
								if (cf_n != 3'd0) act = ACT_WRITE;
								else if (has_res) act = ACT_EMIT;
							end
						end
						FT_FLOW: begin
							if (tx_sent_q != '0) begin
								d_gap     = (g_raw < min_gap_q) ? min_gap_q : g_raw;
								d_block   = fb_q[1];
								d_flow    = 1'b1;
								d_elapsed = '0;
							end
						end
						default: abort_c = 1'b1;
					endcase
				end
			end
			MODE_LOAD: begin
				if (tx_sent_q != '0) begin
					d_tx_sent = '0;
					d_flow    = 1'b0;
					d_block   = '0;
				end
				d_tx_length = new_tl;
				if (req_last_q) begin
					abort_c = 1'b1;
					if (new_tl <= TX_LIMIT_C && id_q != '0) begin
						d_rx_msg_id = id_q;
						d_tx_dest   = id_q;
						act         = ACT_READ;
						has_res     = 1'b1;
						d_res_id    = id_q;
						if (new_tl <= (LEN_W+1)'(7)) begin
							d_frame  = {56'd0, new_tl[7:0]};
							d_lp_idx = 3'd1;
							d_lp_cnt = new_tl[2:0];
						end else begin
							d_frame  = {48'd0, new_tl[7:0], FT_FIRST, new_tl[11:8]};
							d_lp_idx = 3'd2;
							d_lp_cnt = 3'd6;
							ld_multi = 1'b1;
						end
					end
				end
			end
			MODE_TICK: begin
				if (flow_q) begin
					if (el_new < gap_q) begin
						d_elapsed = el_new;
					end else begin
						d_frame   = {56'd0, FT_CONSEC, tx_seq_q};
						d_tx_seq  = tx_seq_q + 4'd1;
						d_lp_addr = tx_sent_q;
						d_lp_idx  = 3'd1;
						d_lp_cnt  = tn;
						act       = ACT_READ;
						has_res   = 1'b1;
						d_res_id  = tx_dest_q;
						if (sent_new >= tx_length_q) begin
							d_tx_length = '0;
							d_tx_sent   = '0;
							d_flow      = 1'b0;
						end else begin
							d_tx_sent = sent_new[LEN_W-1:0];
						end
						if (block_q != 8'd0) begin
							d_block = block_q - 8'd1;
							if (block_q == 8'd1) d_flow = 1'b0;
						end
						d_elapsed = '0;
					end
				end
			end
			default: begin
				if (!rx_inprog_q && rp_q < rx_length_q) begin
					d_rp       = rp_q + LEN_W'(1);
					d_lp_addr  = rp_q;
					d_lp_cnt   = 3'd1;
					act        = ACT_READ;
					has_res    = 1'b1;
					d_res_kind = KIND_BYTE;
					d_res_last = (rp_q + LEN_W'(1) == rx_length_q);
				end
			end
		endcase
		if (abort_c) begin
			d_rx_inprog = 1'b0;
			d_rx_length = '0;
			d_rx_count  = '0;
			d_rx_exp    = 4'd1;
			d_rp        = '0;
			d_tx_length = '0;
			d_tx_sent   = '0;
			d_tx_seq    = 4'd1;
			d_flow      = 1'b0;
			d_block     = '0;
		end
		if (ld_multi) begin
			d_tx_length = new_tl;
			d_tx_sent   = LEN_W'(6);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q   <= MIN_GAP_RESET;
			rx_length_q <= '0;
			rx_count_q  <= '0;
			rp_q        <= '0;
			tx_sent_q   <= '0;
			rx_exp_q    <= 4'd1;
			tx_seq_q    <= 4'd1;
			rx_msg_id_q <= '0;
			tx_dest_q   <= '0;
			rx_inprog_q <= 1'b0;
			flow_q      <= 1'b0;
			tx_length_q <= '0;
			block_q     <= '0;
			gap_q       <= '0;
			elapsed_q   <= '0;
			res_pend_q  <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) min_gap_q <= cfg_wdata;
			if (cmd.dispatch) begin
				rx_length_q <= d_rx_length;
				rx_count_q  <= d_rx_count;
				rp_q        <= d_rp;
				tx_sent_q   <= d_tx_sent;
				rx_exp_q    <= d_rx_exp;
				tx_seq_q    <= d_tx_seq;
				rx_msg_id_q <= d_rx_msg_id;
				tx_dest_q   <= d_tx_dest;
				rx_inprog_q <= d_rx_inprog;
				flow_q      <= d_flow;
				tx_length_q <= d_tx_length;
				block_q     <= d_block;
				gap_q       <= d_gap;
				elapsed_q   <= d_elapsed;
				res_pend_q  <= has_res;
			end
			rd_v_s1 <= cmd.read_step;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q     <= item_in.mode;
			id_q       <= item_in.can_id;
			size_q     <= sz_in;
			req_byte_q <= item_in.req_byte;
			req_last_q <= item_in.req_last;
			for (int i = 0; i < 8; i++) begin
				fb_q[i] <= (4'(i) < sz_in) ? item_in.frame_bytes[8*i +: 8] : 8'd0;
			end
		end
		if (cmd.dispatch) begin
			lp_addr_q  <= d_lp_addr;
			lp_idx_q   <= d_lp_idx;
			lp_cnt_q   <= d_lp_cnt;
			res_kind_q <= d_res_kind;
			res_id_q   <= d_res_id;
			res_len_q  <= d_res_len;
			res_last_q <= d_res_last;
		end else if (cmd.write_step || cmd.read_step) begin
			lp_addr_q <= lp_addr_q + LEN_W'(1);
			lp_idx_q  <= lp_idx_q + 3'd1;
			lp_cnt_q  <= lp_cnt_q - 3'd1;
		end
		rd_dst_s1 <= lp_idx_q;
		if (cmd.dispatch) begin
			frame_q <= d_frame;
		end else if (rd_v_s1) begin
			frame_q[{rd_dst_s1, 3'b000} +: 8] <= rd_data;
		end
		if (cmd.emit) begin
			out_kind_q  <= res_kind_q;
			out_id_q    <= res_id_q;
			out_frame_q <= (res_kind_q == KIND_FRAME) ? frame_q : 64'd0;
			out_len_q   <= res_len_q;
			out_data_q  <= (res_kind_q == KIND_BYTE) ? frame_q[7:0] : 8'd0;
			out_last_q  <= res_last_q;
		end
	end

	assign rd_data = (mode_q == MODE_READ) ? rx_rdata : tx_rdata;

	isotp_ram #(.WIDTH(8), .DEPTH(MAX_MSG_BYTES)) u_rx_ram (
		.clk   (clk),
		.we    (cmd.write_step),
		.waddr (lp_addr_q[AW-1:0]),
		.wdata (fb_q[lp_idx_q]),
		.re    (cmd.read_step && mode_q == MODE_READ),
		.raddr (lp_addr_q[AW-1:0]),
		.rdata (rx_rdata)
	);

	isotp_ram #(.WIDTH(8), .DEPTH(MAX_MSG_BYTES)) u_tx_ram (
		.clk   (clk),
		.we    (cmd.dispatch && tx_we),
		.waddr (tx_waddr),
		.wdata (req_byte_q),
		.re    (cmd.read_step && mode_q != MODE_READ),
		.raddr (lp_addr_q[AW-1:0]),
		.rdata (tx_rdata)
	);

	assign status.act        = act;
	assign status.cnt_last   = (lp_cnt_q == 3'd1);
	assign status.has_result = res_pend_q;
	assign status.out_free   = !out_valid_q || result_out.ready;

	assign result_out.valid      = out_valid_q;
	assign result_out.kind       = out_kind_q;
	assign result_out.out_id     = out_id_q;
	assign result_out.out_frame  = out_frame_q;
	assign result_out.msg_length = out_len_q;
	assign result_out.data_byte  = out_data_q;
	assign result_out.last_byte  = out_last_q;
endmodule

>>> rtl/isotp_segment_reassemble_engine_unit.sv
// ISO-TP segmentation and reassembly engine.
// Channel item_in carries one beat per item: a received CAN frame, one request
// byte to load, a 1 us tick, or a request to read one received byte. Channel
// result_out carries at most one beat per item: a frame to send, a completion
// notice for a received message, or one message byte.
// cfg_we/cfg_wdata write min_gap_us; write it only while the block is idle.
// Sequence: an item is taken in the idle cycle, decided in the next one, then
// copies bytes one per cycle through a buffer RAM port (up to seven for a
// frame, one per read), plus a drain state for reads while the RAM read
// completes, then loads the output register once the output slot is free.
// Reset clears all control state and sets min_gap_us to 5000; the buffers keep
// no reset contents and need no clearing pass.
// When the receiver stalls, the result beat holds in the output register; a later
// item with a result waits with item_in.ready low until that beat is taken.
`include "isotp_segment_reassemble_engine_unit_macros.svh"

module isotp_segment_reassemble_engine_unit #(
	parameter int unsigned MAX_MSG_BYTES = isotp_pkg::MAX_MSG_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	isotp_in_if.sink                    item_in,
	isotp_out_if.source                 result_out,
	input  logic                        cfg_we,
	input  logic [isotp_pkg::GAP_W-1:0] cfg_wdata
);
	import isotp_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	// ready only while the sequencer idles
	assign item_in.ready = in_ready;

	isotp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	isotp_dp #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.status     (status)
	);

	// an accepted beat is always decided in the following cycle
	`ISOTP_ASSERT_NXT(a_take_then_decide, item_in.valid && item_in.ready, cmd.dispatch)
	// never overwrite a result beat that is still waiting
	`ISOTP_ASSERT_IMP(a_emit_slot_free, cmd.emit, !result_out.valid || result_out.ready)
	// hold off new beats while bytes are being copied
	`ISOTP_ASSERT_IMP(a_busy_not_ready, cmd.write_step || cmd.read_step, !item_in.ready)
endmodule
